// File: hdl/dcpi_pkg.sv
// shared types and constants of the dual channel pi speed controller
`timescale 1ns / 1ps
`default_nettype none
package dcpi_pkg;

  localparam int DataW = 16;
  localparam int ErrW  = 17;
  localparam int IntW  = 16;
  localparam int LimW  = 15;
  localparam int GainW = 16;
  localparam int ProdW = 34;
  localparam int SumW  = 35;
  localparam int QuotW = SumW - 8;
  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP_GAIN        = 2'd0,
    CFG_KI_GAIN        = 2'd1,
    CFG_INTEGRAL_LIMIT = 2'd2,
    CFG_OUTPUT_LIMIT   = 2'd3
  } cfg_reg_e;

  localparam logic [GainW-1:0] KpGainRst        = 16'd2560;
  localparam logic [GainW-1:0] KiGainRst        = 16'd512;
  localparam logic [LimW-1:0]  IntegralLimitRst = 15'd3000;
  localparam logic [LimW-1:0]  OutputLimitRst   = 15'd7000;

  // input transaction as held in the first pipeline stage
  typedef struct packed {
    logic                    channel;
    logic signed [DataW-1:0] target_speed;
    logic signed [DataW-1:0] measured_speed;
  } in_item_t;

endpackage
`default_nettype wire

// File: hdl/dcpi_if.sv
// valid/ready channel interfaces for input and result transactions
`timescale 1ns / 1ps
`default_nettype none
interface dcpi_in_if;
  logic                    valid;
  logic                    ready;
  logic                    channel;
  logic signed [15:0]      target_speed;
  logic signed [15:0]      measured_speed;

  modport source (output valid, channel, target_speed, measured_speed, input ready);
  modport sink   (input valid, channel, target_speed, measured_speed, output ready);
endinterface

interface dcpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface
`default_nettype wire

// File: hdl/dcpi_integ.sv
// error computation and per-channel clamped error integral
`timescale 1ns / 1ps
`default_nettype none
module dcpi_integ #(
  parameter int CHANNELS = 2
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              load_i,
  input  wire logic                              channel_i,
  input  wire logic signed [dcpi_pkg::DataW-1:0] target_i,
  input  wire logic signed [dcpi_pkg::DataW-1:0] measured_i,
  input  wire logic        [dcpi_pkg::LimW-1:0]  limit_i,
  output logic signed      [dcpi_pkg::ErrW-1:0]  err_o,
  output logic signed      [dcpi_pkg::IntW-1:0]  integ_o
);

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AccW   = dcpi_pkg::IntW + 2;

  logic signed [dcpi_pkg::IntW-1:0] integ_mem_q [CHANNELS];
  logic        [ChIdxW-1:0]         ch_idx;
  logic signed [dcpi_pkg::ErrW-1:0] err_d;
  logic signed [AccW-1:0]           acc;
  logic signed [AccW-1:0]           lim;
  logic signed [AccW-1:0]           acc_clamped;
  logic signed [dcpi_pkg::IntW-1:0] integ_d;

  // channel number wraps modulo the channel count
  assign ch_idx = (CHANNELS == 1) ? '0 : ChIdxW'(channel_i);

  assign err_d = {target_i[dcpi_pkg::DataW-1], target_i}
               - {measured_i[dcpi_pkg::DataW-1], measured_i};
  assign acc   = {{2{integ_mem_q[ch_idx][dcpi_pkg::IntW-1]}}, integ_mem_q[ch_idx]}
               + {err_d[dcpi_pkg::ErrW-1], err_d};
  assign lim   = signed'({3'b000, limit_i});

  always_comb begin
    if (acc > lim) begin
      acc_clamped = lim;
    end else if (acc < -lim) begin
      acc_clamped = -lim;
    end else begin
      acc_clamped = acc;
    end
  end

  assign integ_d = acc_clamped[dcpi_pkg::IntW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        integ_mem_q[i] <= '0;
      end
    end else if (load_i) begin
      integ_mem_q[ch_idx] <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      err_o   <= err_d;
      integ_o <= integ_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/dcpi_mult.sv
// proportional and integral gain products
`timescale 1ns / 1ps
`default_nettype none
module dcpi_mult (
  input  wire logic                              clk_i,
  input  wire logic                              load_i,
  input  wire logic signed [dcpi_pkg::ErrW-1:0]  err_i,
  input  wire logic signed [dcpi_pkg::IntW-1:0]  integ_i,
  input  wire logic        [dcpi_pkg::GainW-1:0] kp_i,
  input  wire logic        [dcpi_pkg::GainW-1:0] ki_i,
  output logic signed      [dcpi_pkg::ProdW-1:0] kp_prod_o,
  output logic signed      [dcpi_pkg::ProdW-1:0] ki_prod_o
);

  logic signed [dcpi_pkg::GainW:0]   kp_s;
  logic signed [dcpi_pkg::GainW:0]   ki_s;
  logic signed [dcpi_pkg::IntW:0]    integ_s;
  logic signed [dcpi_pkg::ProdW-1:0] kp_prod_d;
  logic signed [dcpi_pkg::ProdW-1:0] ki_prod_d;

  assign kp_s    = signed'({1'b0, kp_i});
  assign ki_s    = signed'({1'b0, ki_i});
  assign integ_s = {integ_i[dcpi_pkg::IntW-1], integ_i};

  assign kp_prod_d = kp_s * err_i;
  assign ki_prod_d = ki_s * integ_s;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kp_prod_o <= kp_prod_d;
      ki_prod_o <= ki_prod_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/dcpi_sat.sv
// sum, truncation toward zero and output saturation
`timescale 1ns / 1ps
`default_nettype none
module dcpi_sat (
  input  wire logic                              clk_i,
  input  wire logic                              load_i,
  input  wire logic signed [dcpi_pkg::ProdW-1:0] kp_prod_i,
  input  wire logic signed [dcpi_pkg::ProdW-1:0] ki_prod_i,
  input  wire logic        [dcpi_pkg::LimW-1:0]  limit_i,
  output logic signed      [dcpi_pkg::DataW-1:0] drive_o
);

  logic signed [dcpi_pkg::SumW-1:0]  sum;
  logic signed [dcpi_pkg::SumW-1:0]  sum_adj;
  logic signed [dcpi_pkg::QuotW-1:0] quot;
  logic signed [dcpi_pkg::QuotW-1:0] lim;
  logic signed [dcpi_pkg::QuotW-1:0] quot_clamped;

  assign sum = {kp_prod_i[dcpi_pkg::ProdW-1], kp_prod_i}
             + {ki_prod_i[dcpi_pkg::ProdW-1], ki_prod_i};
  // bias negative sums so the shift rounds toward zero
  assign sum_adj = sum[dcpi_pkg::SumW-1] ? sum + dcpi_pkg::SumW'(255) : sum;
  assign quot    = sum_adj[dcpi_pkg::SumW-1:8];
  assign lim     = signed'({{(dcpi_pkg::QuotW - dcpi_pkg::LimW){1'b0}}, limit_i});

  always_comb begin
    if (quot > lim) begin
      quot_clamped = lim;
    end else if (quot < -lim) begin
      quot_clamped = -lim;
    end else begin
      quot_clamped = quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drive_o <= quot_clamped[dcpi_pkg::DataW-1:0];
    end
  end

endmodule
`default_nettype wire

// File: hdl/dual_channel_pi_speed_controller_unit.sv
// top level of the dual channel pi speed controller
// latency: a result passes the input register, the integral stage, the product stage and the output register
// throughput: one transaction per cycle while the output is not stalled, through the 4-stage register pipeline
// the channel integral is updated in stage two, so back-to-back same-channel items chain
// reset: asynchronous active low, clears pipeline valids and integrals, loads config defaults
`timescale 1ns / 1ps
`default_nettype none
module dual_channel_pi_speed_controller_unit #(
  parameter int CHANNELS = 2
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  dcpi_in_if.sink                                  in_i,
  dcpi_out_if.source                               out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [dcpi_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [dcpi_pkg::GainW-1:0]          cfg_data_i
);

  // configuration registers
  logic [dcpi_pkg::GainW-1:0] kp_gain_q;
  logic [dcpi_pkg::GainW-1:0] ki_gain_q;
  logic [dcpi_pkg::LimW-1:0]  integral_limit_q;
  logic [dcpi_pkg::LimW-1:0]  output_limit_q;

  // pipeline valids, one per stage
  logic s1_valid_q;
  logic s2_valid_q;
  logic s3_valid_q;
  logic out_valid_q;

  // stage advance enables: a stage moves when its successor is empty or moving
  logic out_en;
  logic s3_en;
  logic s2_en;
  logic s1_en;

  dcpi_pkg::in_item_t s1_item_q;

  logic signed [dcpi_pkg::ErrW-1:0]  err;
  logic signed [dcpi_pkg::IntW-1:0]  integ;
  logic signed [dcpi_pkg::ProdW-1:0] kp_prod;
  logic signed [dcpi_pkg::ProdW-1:0] ki_prod;
  logic signed [dcpi_pkg::DataW-1:0] drive;

  assign out_en = !out_valid_q || out_o.ready;
  assign s3_en  = !s3_valid_q || out_en;
  assign s2_en  = !s2_valid_q || s3_en;
  assign s1_en  = !s1_valid_q || s2_en;

  assign in_i.ready  = s1_en;
  assign out_o.valid = out_valid_q;
  assign out_o.drive = drive;

  // config writes; the user must issue them only while the pipeline is drained, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_gain_q        <= dcpi_pkg::KpGainRst;
      ki_gain_q        <= dcpi_pkg::KiGainRst;
      integral_limit_q <= dcpi_pkg::IntegralLimitRst;
      output_limit_q   <= dcpi_pkg::OutputLimitRst;
    end else if (cfg_we_i) begin
      case (dcpi_pkg::cfg_reg_e'(cfg_idx_i))
        dcpi_pkg::CFG_KP_GAIN:        kp_gain_q        <= cfg_data_i;
        dcpi_pkg::CFG_KI_GAIN:        ki_gain_q        <= cfg_data_i;
        dcpi_pkg::CFG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data_i[dcpi_pkg::LimW-1:0];
        dcpi_pkg::CFG_OUTPUT_LIMIT:   output_limit_q   <= cfg_data_i[dcpi_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  // valid bits of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_en) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // input register, loaded on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_en) begin
      s1_item_q.channel        <= in_i.channel;
      s1_item_q.target_speed   <= in_i.target_speed;
      s1_item_q.measured_speed <= in_i.measured_speed;
    end
  end

  // stage two: error and clamped integral; the integral store is written here
  dcpi_integ #(
    .CHANNELS (CHANNELS)
  ) u_integ (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s1_valid_q && s2_en),
    .channel_i  (s1_item_q.channel),
    .target_i   (s1_item_q.target_speed),
    .measured_i (s1_item_q.measured_speed),
    .limit_i    (integral_limit_q),
    .err_o      (err),
    .integ_o    (integ)
  );

  // stage three: gain products
  dcpi_mult u_mult (
    .clk_i     (clk_i),
    .load_i    (s2_valid_q && s3_en),
    .err_i     (err),
    .integ_i   (integ),
    .kp_i      (kp_gain_q),
    .ki_i      (ki_gain_q),
    .kp_prod_o (kp_prod),
    .ki_prod_o (ki_prod)
  );

  // output register: truncated and saturated drive
  dcpi_sat u_sat (
    .clk_i     (clk_i),
    .load_i    (s3_valid_q && out_en),
    .kp_prod_i (kp_prod),
    .ki_prod_i (ki_prod),
    .limit_i   (output_limit_q),
    .drive_o   (drive)
  );

endmodule
`default_nettype wire

// File: hdl/dcpi_checker.sv
// port-level checks of the controller, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module dcpi_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] drive_i
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_i))
    else $error("result changed while stalled");

  // the limit is at most 32767, so the most negative code never appears
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> drive_i != 16'h8000)
    else $error("drive outside saturation range");

  // with the output free the whole pipeline moves, so input is taken
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled with output free");

  // input stall only arises from an output stall
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind dual_channel_pi_speed_controller_unit dcpi_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .drive_i     (out_o.drive)
);
`default_nettype wire
